>>> hw/rtl/prw_pkg.sv
// Shared types and constants for the particle weight resampler.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package prw_pkg;

  // Field and store widths.
  localparam int IDX_W    = 8;
  localparam int SLOTS    = 1 << IDX_W;
  localparam int WEIGHT_W = 17;
  localparam int CUM_W    = 25;
  localparam int SQ_W     = 41;
  localparam int WORD_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int CNT_W    = 9;
  localparam int THR_W    = CUM_W + FRAC_W;

  // The 41-bit square sum is multiplied by the count in two halves.
  localparam int SQ_LO_W  = 21;
  localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
  localparam int LHS_LO_W = SQ_LO_W + CNT_W;
  localparam int LHS_HI_W = SQ_HI_W + CNT_W;
  localparam int LHS_W    = SQ_W + CNT_W;
  localparam int RHS_W    = 2 * CUM_W;

  // Largest usable particle count.
  localparam int MAX_PARTICLES = 256;
  localparam int COUNT_BOUND   = (MAX_PARTICLES < SLOTS) ? MAX_PARTICLES : SLOTS;
  localparam logic [CNT_W-1:0] COUNT_BOUND_V = CNT_W'(COUNT_BOUND);
  localparam logic [CNT_W-1:0] COUNT_RESET   = CNT_W'(256);

  // Weight of one in Q1.16.
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

  // Request function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE = 1'b1;

  // Request and result payloads.
  typedef struct packed {
    logic                func;
    logic [IDX_W-1:0]    slot;
    logic [WEIGHT_W-1:0] particle_weight;
    logic [WORD_W-1:0]   pos_x;
    logic [WORD_W-1:0]   pos_y;
    logic [WORD_W-1:0]   scale;
    logic [FRAC_W-1:0]   random_fraction;
  } prw_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]    source_index;
    logic [WEIGHT_W-1:0] out_weight;
    logic [WORD_W-1:0]   out_x;
    logic [WORD_W-1:0]   out_y;
    logic [WORD_W-1:0]   out_scale;
    logic                resampled;
  } prw_out_t;

  // Read address source for the stores.
  typedef enum logic [1:0] {
    ADDR_MID  = 2'd0,
    ADDR_IDX  = 2'd1,
    ADDR_PICK = 2'd2
  } addr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      load_wr;
    logic      mul_en;
    logic      eval;
    logic      bin_chk;
    logic      lin_chk;
    logic      emit;
    addr_sel_t addr_sel;
  } prw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_draw;
    logic skip;
    logic mono;
    logic pred;
    logic lo_eq_hi;
    logic hi_last;
    logic idx_last;
    logic out_full;
  } prw_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/prw_in_if.sv
// Request channel of the particle weight resampler: valid, ready and payload.
// Depends on prw_pkg for the payload type.
`default_nettype none

interface prw_in_if;
  import prw_pkg::*;

  logic    valid;
  logic    ready;
  prw_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/prw_out_if.sv
// Result channel of the particle weight resampler: valid, ready and payload.
// Depends on prw_pkg for the payload type.
`default_nettype none

interface prw_out_if;
  import prw_pkg::*;

  logic     valid;
  logic     ready;
  prw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/prw_ctrl.sv
// Sequencing state machine of the particle weight resampler.
// Depends on prw_pkg for the command and status structs.
`default_nettype none

module prw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  prw_pkg::prw_sts_t sts,
  output prw_pkg::prw_cmd_t cmd
);
  import prw_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_LOAD = 10'b00_0000_0010,
    S_MUL  = 10'b00_0000_0100,
    S_CMP  = 10'b00_0000_1000,
    S_BRD  = 10'b00_0001_0000,
    S_BCHK = 10'b00_0010_0000,
    S_LRD  = 10'b00_0100_0000,
    S_LCHK = 10'b00_1000_0000,
    S_READ = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_PICK;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.req_draw ? S_MUL : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.eval = 1'b1;
        if (sts.skip) begin
          state_nxt = S_READ;
        end else if (sts.mono) begin
          state_nxt = S_BRD;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_BRD: begin
        cmd.addr_sel = ADDR_MID;
        state_nxt    = S_BCHK;
      end
      S_BCHK: begin
        cmd.bin_chk = 1'b1;
        if (!sts.lo_eq_hi) begin
          state_nxt = S_BRD;
        end else if (sts.pred || sts.hi_last) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        cmd.addr_sel = ADDR_IDX;
        state_nxt    = S_LCHK;
      end
      S_LCHK: begin
        cmd.lin_chk = 1'b1;
        state_nxt   = (sts.pred || sts.idx_last) ? S_READ : S_LRD;
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/prw_datapath.sv
// Datapath of the particle weight resampler: particle stores, running sums,
// effective sample size test, search registers and result register. Uses prw_pkg.
`default_nettype none

module prw_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [prw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  prw_pkg::prw_in_t                 in_data,
  input  prw_pkg::prw_cmd_t                cmd,
  output prw_pkg::prw_sts_t                sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output prw_pkg::prw_out_t                out_data
);
  import prw_pkg::*;

  // Configuration.
  logic [CNT_W-1:0] count_r;
  logic             adaptive_r;

  // Captured request.
  logic [IDX_W-1:0]    req_slot_r;
  logic [WEIGHT_W-1:0] req_w_r;
  logic [WORD_W-1:0]   req_x_r, req_y_r, req_scale_r;
  logic [FRAC_W-1:0]   req_frac_r;

  // Running sums and load order tracking.
  logic [CUM_W-1:0] weight_total_r;
  logic [SQ_W-1:0]  square_total_r;
  logic             mono_r;
  logic [IDX_W-1:0] last_r;

  // Products.
  logic [LHS_LO_W-1:0] lhs_lo_r;
  logic [LHS_HI_W-1:0] lhs_hi_r;
  logic [RHS_W-1:0]    rhs_r;
  logic [THR_W-1:0]    thresh_r;

  // Search registers.
  logic [IDX_W-1:0] lo_r, hi_r, idx_r, pick_r;
  logic             resampled_r;

  // Particle stores and their registered read data.
  logic [WEIGHT_W-1:0] weight_mem [SLOTS];
  logic [CUM_W-1:0]    cum_mem    [SLOTS];
  logic [WORD_W-1:0]   x_mem      [SLOTS];
  logic [WORD_W-1:0]   y_mem      [SLOTS];
  logic [WORD_W-1:0]   scale_mem  [SLOTS];
  logic [WEIGHT_W-1:0] w_q;
  logic [CUM_W-1:0]    cum_q;
  logic [WORD_W-1:0]   x_q, y_q, s_q;

  // Result register.
  logic     out_valid_r;
  prw_out_t out_data_r;

  // Combinational terms.
  logic [CNT_W-1:0]    n_use;
  logic [IDX_W-1:0]    nm1;
  logic [CUM_W-1:0]    base_t;
  logic [CUM_W:0]      sum_t;
  logic [CUM_W-1:0]    new_t;
  logic [SQ_W-1:0]     base_s;
  logic [2*WEIGHT_W-1:0] w_sq;
  logic [SQ_W:0]       sum_s;
  logic [SQ_W-1:0]     new_s;
  logic [LHS_W-1:0]    lhs;
  logic                skip;
  logic                pred;
  logic [IDX_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic [IDX_W-1:0]    rd_addr;

  // Count in use: zero counts as one, larger values clamp to the bound.
  always_comb begin
    if (count_r == '0) begin
      n_use = CNT_W'(1);
    end else if (count_r > COUNT_BOUND_V) begin
      n_use = COUNT_BOUND_V;
    end else begin
      n_use = count_r;
    end
    nm1 = IDX_W'(n_use - CNT_W'(1));
  end

  // Saturating running sums for a load; slot zero restarts them.
  always_comb begin
    base_t = (req_slot_r == '0) ? '0 : weight_total_r;
    base_s = (req_slot_r == '0) ? '0 : square_total_r;
    sum_t  = {1'b0, base_t} + (CUM_W + 1)'(req_w_r);
    new_t  = sum_t[CUM_W] ? {CUM_W{1'b1}} : sum_t[CUM_W-1:0];
    w_sq   = (2 * WEIGHT_W)'(req_w_r) * (2 * WEIGHT_W)'(req_w_r);
    sum_s  = {1'b0, base_s} + (SQ_W + 1)'(w_sq);
    new_s  = sum_s[SQ_W] ? {SQ_W{1'b1}} : sum_s[SQ_W-1:0];
  end

  // Effective sample size test and threshold compare.
  always_comb begin
    lhs     = (LHS_W'(lhs_hi_r) << SQ_LO_W) + LHS_W'(lhs_lo_r);
    skip    = adaptive_r && !({1'b0, lhs} > {rhs_r, 1'b0});
    pred    = {cum_q, {FRAC_W{1'b0}}} > thresh_r;
    mid_sum = (IDX_W + 1)'(lo_r) + (IDX_W + 1)'(hi_r);
    mid     = mid_sum[IDX_W:1];
  end

  // Store read address.
  always_comb begin
    case (cmd.addr_sel)
      ADDR_MID:  rd_addr = mid;
      ADDR_IDX:  rd_addr = idx_r;
      ADDR_PICK: rd_addr = pick_r;
      default:   rd_addr = pick_r;
    endcase
  end

  // Status to the controller.
  always_comb begin
    sts.req_draw = (in_data.func == FUNC_DRAW);
    sts.skip     = skip;
    sts.mono     = mono_r;
    sts.pred     = pred;
    sts.lo_eq_hi = (lo_r == hi_r);
    sts.hi_last  = (hi_r == nm1);
    sts.idx_last = (idx_r == nm1);
    sts.out_full = out_valid_r && !out_ready;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= COUNT_RESET;
      adaptive_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT:    count_r    <= cfg_wdata;
        CFG_ADAPTIVE: adaptive_r <= cfg_wdata[0];
        default:      count_r    <= count_r;
      endcase
    end
  end

  // Request capture; the weight is saturated to one here.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_slot_r  <= in_data.slot;
      req_w_r     <= (in_data.particle_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                            : in_data.particle_weight;
      req_x_r     <= in_data.pos_x;
      req_y_r     <= in_data.pos_y;
      req_scale_r <= in_data.scale;
      req_frac_r  <= in_data.random_fraction;
    end
  end

  // Sums and load order. The cumulative store is known monotonic over
  // slots zero to last while loads arrive in consecutive slot order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_total_r <= '0;
      square_total_r <= '0;
      mono_r         <= 1'b0;
      last_r         <= '0;
    end else if (cmd.load_wr) begin
      weight_total_r <= new_t;
      square_total_r <= new_s;
      if (req_slot_r == '0) begin
        mono_r <= 1'b1;
        last_r <= '0;
      end else if (mono_r && ((IDX_W + 1)'(req_slot_r) == (IDX_W + 1)'(last_r) + 1'b1)) begin
        last_r <= req_slot_r;
      end else begin
        mono_r <= 1'b0;
      end
    end
  end

  // Registered products for the draw; the square-sum product is split in two.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      lhs_lo_r <= LHS_LO_W'(square_total_r[SQ_LO_W-1:0]) * LHS_LO_W'(n_use);
      lhs_hi_r <= LHS_HI_W'(square_total_r[SQ_W-1:SQ_LO_W]) * LHS_HI_W'(n_use);
      rhs_r    <= RHS_W'(weight_total_r) * RHS_W'(weight_total_r);
      thresh_r <= THR_W'(req_frac_r) * THR_W'(weight_total_r);
    end
  end

  // Search: binary search over the monotonic prefix, then a linear scan over
  // the rest; no match picks the last particle in use, a skipped draw its slot.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      lo_r  <= '0;
      hi_r  <= (last_r < nm1) ? last_r : nm1;
      idx_r <= '0;
      if (skip) begin
        pick_r      <= req_slot_r;
        resampled_r <= 1'b0;
      end else begin
        resampled_r <= 1'b1;
      end
    end else if (cmd.bin_chk) begin
      if (lo_r != hi_r) begin
        if (pred) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + IDX_W'(1);
        end
      end else if (pred) begin
        pick_r <= lo_r;
      end else if (hi_r == nm1) begin
        pick_r <= nm1;
      end else begin
        idx_r <= hi_r + IDX_W'(1);
      end
    end else if (cmd.lin_chk) begin
      if (pred) begin
        pick_r <= idx_r;
      end else if (idx_r == nm1) begin
        pick_r <= nm1;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Store write on load.
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      weight_mem[req_slot_r] <= req_w_r;
      cum_mem[req_slot_r]    <= new_t;
      x_mem[req_slot_r]      <= req_x_r;
      y_mem[req_slot_r]      <= req_y_r;
      scale_mem[req_slot_r]  <= req_scale_r;
    end
  end

  // Registered store read.
  always_ff @(posedge clk) begin
    w_q   <= weight_mem[rd_addr];
    cum_q <= cum_mem[rd_addr];
    x_q   <= x_mem[rd_addr];
    y_q   <= y_mem[rd_addr];
    s_q   <= scale_mem[rd_addr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.source_index <= pick_r;
      out_data_r.out_weight   <= w_q;
      out_data_r.out_x        <= x_q;
      out_data_r.out_y        <= y_q;
      out_data_r.out_scale    <= s_q;
      out_data_r.resampled    <= resampled_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/particle_weight_resampler.sv
// Top level of the particle weight resampler: controller plus datapath.
// Depends on prw_pkg, prw_in_if, prw_out_if, prw_ctrl and prw_datapath.
//
//   Channel     Direction  Handshake            Carries
//   in_chan     in         valid / ready        load or draw request
//   out_chan    out        valid / ready        one result per draw
//   cfg_*       in         write enable only    particle_count, adaptive_mode
//
// A load is captured, then written to the stores. A draw is captured, forms its
// products, runs the sample size test, reads the store and emits; a resampled draw
// adds a binary search over L particles loaded in slot order and any linear scan,
// each probe a read then a check, on the single read port of the cumulative store.
// Reset clears the sums, the load order flag and adaptive mode, sets the count to
// 256 and spares the stores. A finished result waits in the output register while
// the next request is taken; a further one then holds the controller until it drains.
`default_nettype none

module particle_weight_resampler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [prw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  prw_in_if.sink                         in_chan,
  prw_out_if.source                      out_chan
);
  import prw_pkg::*;

  prw_cmd_t cmd;
  prw_sts_t sts;

  prw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_chan.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for particle_weight_resampler: drives load and draw requests,
// predicts every selection in SystemVerilog and checks each result as it drains.
// Depends on prw_pkg, prw_in_if, prw_out_if and the particle_weight_resampler RTL.
`timescale 1ns / 100ps

module tb;
  import prw_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam longint unsigned CUM_MAX = (64'd1 << CUM_W) - 64'd1;
  localparam longint unsigned SQ_MAX  = (64'd1 << SQ_W) - 64'd1;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  prw_in_if  in_chan ();
  prw_out_if out_chan ();

  particle_weight_resampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // Mirror of the particle stores, the running sums and the registers.
  logic [WEIGHT_W-1:0] w_mem   [SLOTS];
  logic [CUM_W-1:0]    cum_mem [SLOTS];
  logic [WORD_W-1:0]   x_mem   [SLOTS];
  logic [WORD_W-1:0]   y_mem   [SLOTS];
  logic [WORD_W-1:0]   sc_mem  [SLOTS];
  logic [CUM_W-1:0]    sum_w        = '0;
  logic [SQ_W-1:0]     sum_sq       = '0;
  logic [CNT_W-1:0]    count_reg    = COUNT_RESET;
  logic                adaptive_reg = 1'b0;

  // Selections that the block still owes, oldest first.
  prw_out_t picks_due [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int loads_sent    = 0;
  int draws_sent    = 0;
  int results_seen  = 0;
  int skips_seen    = 0;
  int mismatches    = 0;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: run limit of %0d cycles reached with %0d results outstanding",
             CYCLE_LIMIT, picks_due.size());
    $display("tb: failure");
    $finish;
  end

  // Receiver: back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Selection predictor, applied to every request when the block takes it.
  function automatic void predict_request(input prw_in_t req);
    logic [WEIGHT_W-1:0] w;
    longint unsigned wl, run, sq, total, fr, lhs, rhs, thresh, scaled;
    int unsigned n;
    int unsigned pick;
    prw_out_t res;
    if (req.func == FUNC_LOAD) begin
      loads_sent++;
      w = (req.particle_weight > WEIGHT_ONE) ? WEIGHT_ONE : req.particle_weight;
      // A load to slot zero starts a new frame.
      if (req.slot == '0) begin
        sum_w  = '0;
        sum_sq = '0;
      end
      wl  = w;
      run = sum_w;
      run = run + wl;
      if (run > CUM_MAX) run = CUM_MAX;
      sq = sum_sq;
      sq = sq + wl * wl;
      if (sq > SQ_MAX) sq = SQ_MAX;
      sum_w  = run[CUM_W-1:0];
      sum_sq = sq[SQ_W-1:0];
      w_mem[req.slot]   = w;
      cum_mem[req.slot] = run[CUM_W-1:0];
      x_mem[req.slot]   = req.pos_x;
      y_mem[req.slot]   = req.pos_y;
      sc_mem[req.slot]  = req.scale;
    end else begin
      draws_sent++;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > COUNT_BOUND) n = COUNT_BOUND;
      total = sum_w;
      sq    = sum_sq;
      lhs   = sq * n;
      rhs   = 64'd2 * total * total;
      pick  = req.slot;
      res.resampled = 1'b0;
      // Effective sample size test; when it fails the slot keeps its own particle.
      if (!adaptive_reg || lhs > rhs) begin
        res.resampled = 1'b1;
        fr     = req.random_fraction;
        thresh = total * fr;
        pick   = n - 1;
        // Scan downward so the lowest slot above the threshold wins.
        for (int j = n - 1; j >= 0; j--) begin
          scaled = cum_mem[IDX_W'(j)];
          scaled = scaled << FRAC_W;
          if (scaled > thresh) pick = j;
        end
      end
      res.source_index = pick[IDX_W-1:0];
      res.out_weight   = w_mem[res.source_index];
      res.out_x        = x_mem[res.source_index];
      res.out_y        = y_mem[res.source_index];
      res.out_scale    = sc_mem[res.source_index];
      picks_due.insert(picks_due.size(), res);
    end
  endfunction

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    prw_out_t want;
    prw_out_t got;
    logic bad;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got = out_chan.data;
      if (picks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no draw outstanding: src %0d w %h x %h y %h s %h r %b",
                   $realtime, got.source_index, got.out_weight, got.out_x, got.out_y,
                   got.out_scale, got.resampled);
      end else begin
        want = picks_due.pop_front();
        results_seen++;
        if (!want.resampled) skips_seen++;
        bad = (got.source_index !== want.source_index) ||
              (got.out_weight   !== want.out_weight)   ||
              (got.out_x        !== want.out_x)        ||
              (got.out_y        !== want.out_y)        ||
              (got.out_scale    !== want.out_scale)    ||
              (got.resampled    !== want.resampled);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch, expected src %0d w %h x %h y %h s %h r %b",
                     $realtime, want.source_index, want.out_weight, want.out_x,
                     want.out_y, want.out_scale, want.resampled);
            $display("%0t:                     actual src %0d w %h x %h y %h s %h r %b",
                     $realtime, got.source_index, got.out_weight, got.out_x,
                     got.out_y, got.out_scale, got.resampled);
          end
        end
      end
    end
  end

  // Idling profile: 0 none, 1 sender idle, 2 receiver stalling, 3 both lightly.
  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 67; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 67; end
      default: begin send_idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  // Presents one request, holds it until it is taken, then predicts its effect.
  task automatic send_req(input prw_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= req;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    predict_request(req);
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_COUNT) count_reg = val;
    else adaptive_reg = val[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Request with every field random; callers then set the fields that matter.
  function automatic prw_in_t random_payload();
    prw_in_t req;
    req.func            = 1'($urandom_range(0, 1));
    req.slot            = IDX_W'($urandom_range(0, SLOTS - 1));
    req.particle_weight = WEIGHT_W'($urandom_range(0, (1 << WEIGHT_W) - 1));
    req.pos_x           = WORD_W'($urandom_range(0, 65535));
    req.pos_y           = WORD_W'($urandom_range(0, 65535));
    req.scale           = WORD_W'($urandom_range(0, 65535));
    req.random_fraction = FRAC_W'($urandom_range(0, 65535));
    return req;
  endfunction

  task automatic send_load(input logic [IDX_W-1:0] slot, input logic [WEIGHT_W-1:0] w);
    prw_in_t req;
    req                 = random_payload();
    req.func            = FUNC_LOAD;
    req.slot            = slot;
    req.particle_weight = w;
    send_req(req);
  endtask

  task automatic send_draw(input logic [IDX_W-1:0] slot, input logic [FRAC_W-1:0] frac);
    prw_in_t req;
    req                 = random_payload();
    req.func            = FUNC_DRAW;
    req.slot            = slot;
    req.random_fraction = frac;
    send_req(req);
  endtask

  // Weight mix: zero, exactly one, above one, tiny, and anything the field holds.
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WEIGHT_ONE;
      2: return '1;
      3: return WEIGHT_W'($urandom_range(0, 255));
      default: return WEIGHT_W'($urandom_range(0, (1 << WEIGHT_W) - 1));
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return FRAC_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_count();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd2;
      3: return 9'd255;
      4: return 9'd256;
      5: return 9'd511;
      default: return CFG_DATA_W'($urandom_range(1, 32));
    endcase
  endfunction

  // Small frames for the special cases; only slots 0 to 3 are ever read here.
  task automatic test_directed();
    set_idling(0);
    write_reg(CFG_COUNT, 9'd4);
    write_reg(CFG_ADAPTIVE, 9'd0);
    // Weight above one, zero weight, exactly one, and the smallest nonzero weight.
    send_load(8'd0, '1);
    send_load(8'd1, '0);
    send_load(8'd2, WEIGHT_ONE);
    send_load(8'd3, 17'd1);
    send_draw(8'hFF, 16'h0000);
    send_draw(8'h00, 16'hFFFF);
    send_draw(8'h80, 16'h8000);
    // Spread weights fail the sample size test, so adaptive draws keep their slot.
    drain_results();
    write_reg(CFG_ADAPTIVE, 9'd1);
    send_draw(8'd1, rand_frac());
    send_draw(8'd3, rand_frac());
    // One dominant particle passes the test and forces resampling.
    send_load(8'd0, WEIGHT_ONE);
    send_load(8'd1, '0);
    send_load(8'd2, '0);
    send_load(8'd3, '0);
    send_draw(8'd2, 16'h4000);
    // A count of zero behaves as one particle.
    drain_results();
    write_reg(CFG_COUNT, 9'd0);
    write_reg(CFG_ADAPTIVE, 9'd0);
    send_draw(8'd3, 16'hFFFF);
    // All weights zero: nothing exceeds the threshold and the last particle wins.
    drain_results();
    write_reg(CFG_COUNT, 9'd4);
    for (int j = 0; j < 4; j++) send_load(IDX_W'(j), '0);
    send_draw(8'd0, 16'h0000);
    // Loads out of slot order leave the cumulative weights unsorted.
    send_load(8'd0, 17'd100);
    send_load(8'd3, WEIGHT_ONE);
    send_load(8'd1, 17'd5);
    send_draw(8'd2, 16'hFFFF);
    send_draw(8'd1, 16'h0001);
  endtask

  // Every slot loaded once with a weight of one, so the sums reach half their
  // range; from here on no store entry is unwritten.
  task automatic test_full_frame();
    set_idling(3);
    drain_results();
    write_reg(CFG_COUNT, 9'd511);
    for (int j = 0; j < SLOTS; j++)
      send_load(IDX_W'(j), ($urandom_range(0, 1) != 0) ? WEIGHT_ONE : '1);
    for (int j = 0; j < 6; j++) send_draw(IDX_W'($urandom_range(0, SLOTS - 1)), rand_frac());
    drain_results();
    write_reg(CFG_COUNT, 9'd256);
    write_reg(CFG_ADAPTIVE, 9'd1);
    for (int j = 0; j < 4; j++) send_draw(IDX_W'($urandom_range(0, SLOTS - 1)), rand_frac());
  endtask

  // Loads that never touch slot zero, on top of the full frame, until the
  // running sums saturate.
  task automatic test_sum_saturation();
    set_idling(0);
    drain_results();
    write_reg(CFG_ADAPTIVE, 9'd0);
    for (int j = 0; j < 257; j++)
      send_load(IDX_W'(1 + (j % (SLOTS - 1))),
                ($urandom_range(0, 1) != 0) ? WEIGHT_ONE : '1);
    for (int j = 0; j < 4; j++) send_draw(IDX_W'($urandom_range(0, SLOTS - 1)), rand_frac());
    drain_results();
    write_reg(CFG_ADAPTIVE, 9'd1);
    for (int j = 0; j < 2; j++) send_draw(IDX_W'($urandom_range(0, SLOTS - 1)), rand_frac());
  endtask

  // Mostly well-formed frames with random content, some stray loads and draws.
  task automatic test_random_phases();
    int sent;
    int len;
    int style;
    int hot;
    int ndraw;
    int roll;
    bit paused;
    logic [WEIGHT_W-1:0] level;
    logic [WEIGHT_W-1:0] w;
    for (int p = 0; p < 4; p++) begin
      drain_results();
      set_idling(p);
      write_reg(CFG_COUNT, rand_count());
      write_reg(CFG_ADAPTIVE, CFG_DATA_W'($urandom_range(0, 511)));
      sent   = 0;
      paused = 1'b0;
      while (sent < 20) begin
        // Once per phase the sender holds off until the block has drained.
        if (sent >= 10 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
          len   = $urandom_range(1, 12);
          style = $urandom_range(0, 2);
          hot   = $urandom_range(0, len - 1);
          level = rand_weight();
          for (int j = 0; j < len; j++) begin
            case (style)
              0: w = rand_weight();
              1: w = (j == hot) ? WEIGHT_ONE : 17'($urandom_range(0, 15));
              default: w = level;
            endcase
            send_load(IDX_W'(j), w);
          end
          ndraw = $urandom_range(1, 6);
          for (int j = 0; j < ndraw; j++)
            send_draw(IDX_W'($urandom_range(0, SLOTS - 1)), rand_frac());
          sent += len + ndraw;
        end else if (roll < 9) begin
          send_load(IDX_W'($urandom_range(1, SLOTS - 1)), rand_weight());
          sent++;
        end else begin
          send_draw(IDX_W'($urandom_range(0, SLOTS - 1)), rand_frac());
          sent++;
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_frame();
    test_sum_saturation();
    test_random_phases();
    drain_results();

    $display("tb: %0d loads and %0d draws sent, counts 0 to 511, adaptive on and off",
             loads_sent, draws_sent);
    $display("tb: %0d results checked (%0d skipped draws), %0d mismatches",
             results_seen, skips_seen, mismatches);
    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
